/* rtl/cset_pkg.sv */
package cset_pkg;

  // Field widths of the trace event and of the profiling result.
  localparam int ID_W       = 8;
  localparam int TS_W       = 32;
  localparam int SLICE_W    = 33;
  localparam int TOTAL_W    = 48;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;

  // Event kinds as carried on the input tuser bit.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_START    = 2'd0;
  localparam logic [1:0] STATUS_END      = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  // Operation decided by the front end for each event.
  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_OVERFLOW  = 2'd2,
    OP_UNDERFLOW = 2'd3
  } op_t;

  // One classified event waiting in the queue.
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [TS_W-1:0]  ts;
  } entry_t;

endpackage

/* rtl/call_stack_exclusive_time_core.sv */
// Exclusive-time profiler for call and return trace events.
// Input stream: one beat per event. s_tuser is the kind (0 start, 1 end),
// s_tdata carries the function id and the timestamp. Output stream: one
// beat per event with status, function id, exclusive slice and the
// function's running saturated total.
// A front end classifies each event against the stack occupancy and puts it
// into a two-entry queue; a back end sequencer runs it against the frame
// and totals memories, whose registered reads set the timing.
// The back end runs a start or an error through a read and an emit step,
// and an end through read, elapsed, slice and accumulate steps; it takes
// a new event from the queue only once it is through with the last one.
// After reset the stack is empty and the totals memory is cleared in a
// pass over all FUNC_COUNT entries during which s_tready stays low.
// When the receiver stalls, the result waits in the output register, the
// back end holds, and the queue keeps taking up to two further events.
module call_stack_exclusive_time_core #(
  parameter int FUNC_COUNT  = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: func_id [7:0], timestamp [39:8]
  input  logic [cset_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: kind [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: status [1:0], func_id_out [9:2], slice_time [42:10],
  //          total_time [90:43], zero [95:91]
  output logic [cset_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic             clear_busy;
  cset_pkg::entry_t q_entry;
  cset_pkg::entry_t q_head;

  // Event classification and stack occupancy.
  cset_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (!clear_busy),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Decoupling queue between front and back.
  cset_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Stack frames, totals and result register.
  cset_back #(.FUNC_COUNT(FUNC_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

/* rtl/cset_ram.sv */
module cset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cset_front.sv */
module cset_front #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             enable,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cset_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output cset_pkg::entry_t                 q_entry
);

  localparam int LW = $clog2(STACK_DEPTH + 1);

  logic [LW-1:0] level;
  logic          full_stack;
  logic          empty_stack;

  assign full_stack  = (level >= LW'(STACK_DEPTH));
  assign empty_stack = (level == '0);

  // Take a beat whenever the queue has room and the totals are cleared.
  assign s_tready = enable && !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Classify the event against the stack occupancy seen so far.
  always_comb begin
    q_entry.id = s_tdata[cset_pkg::ID_W-1:0];
    q_entry.ts = s_tdata[cset_pkg::ID_W +: cset_pkg::TS_W];
    if (s_tuser == cset_pkg::KIND_START) begin
      q_entry.op = full_stack ? cset_pkg::OP_OVERFLOW : cset_pkg::OP_PUSH;
    end else begin
      q_entry.op = empty_stack ? cset_pkg::OP_UNDERFLOW : cset_pkg::OP_POP;
    end
  end

  // Stack occupancy as the back end will see it once the queue drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (q_push) begin
      if (q_entry.op == cset_pkg::OP_PUSH) begin
        level <= level + LW'(1);
      end else if (q_entry.op == cset_pkg::OP_POP) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

/* rtl/cset_queue.sv */
module cset_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cset_pkg::entry_t  wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output cset_pkg::entry_t  head
);

  cset_pkg::entry_t slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rptr];

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

  // Two-entry ring with an occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/cset_back.sv */
module cset_back #(
  parameter int FUNC_COUNT  = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  cset_pkg::entry_t                q_head,
  output logic                            q_pop,
  output logic                            clear_busy,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cset_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int FAW = (FUNC_COUNT > 1) ? $clog2(FUNC_COUNT) : 1;
  localparam int SW  = cset_pkg::SLICE_W;
  localparam int TW  = cset_pkg::TOTAL_W;
  localparam int PAD = cset_pkg::OUT_DATA_W - TW - SW - cset_pkg::ID_W - 2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_SLICE = 5'b01000,
    S_ACC   = 5'b10000
  } state_t;

  state_t                    state;
  logic [FAW-1:0]            clr_cnt;
  logic [LW-1:0]             blevel;
  logic [LW-1:0]             lvl_m1;
  logic [LW-1:0]             lvl_m2;
  logic [SW-1:0]             topchild;

  // Work registers of the event in progress.
  cset_pkg::op_t             w_op;
  logic [cset_pkg::ID_W-1:0] w_id;
  logic [cset_pkg::TS_W-1:0] w_ts;
  logic                      w_inrange;
  logic                      w_has_parent;
  logic [SW-1:0]             elapsed;
  logic [SW-1:0]             parent_child;
  logic [TW-1:0]             total;
  logic [SW-1:0]             slice;

  // Memory ports.
  logic                      start_we;
  logic                      start_re;
  logic [SAW-1:0]            start_waddr;
  logic [SAW-1:0]            start_raddr;
  logic [cset_pkg::TS_W-1:0] start_rdata;
  logic                      child_we;
  logic                      child_re;
  logic [SAW-1:0]            child_waddr;
  logic [SAW-1:0]            child_raddr;
  logic [SW-1:0]             child_rdata;
  logic                      tot_we;
  logic                      tot_re;
  logic [FAW-1:0]            tot_waddr;
  logic [FAW-1:0]            tot_raddr;
  logic [TW-1:0]             tot_wdata;
  logic [TW-1:0]             tot_rdata;

  // Datapath results.
  logic                      take;
  logic                      out_free;
  logic                      emit;
  logic [SW-1:0]             elapsed_calc;
  logic [SW-1:0]             slice_calc;
  logic [SW:0]               child_sum;
  logic [SW-1:0]             child_sat;
  logic [TW:0]               tot_sum;
  logic [TW-1:0]             tot_sat;
  logic [1:0]                w_status;

  assign lvl_m1     = blevel - LW'(1);
  assign lvl_m2     = blevel - LW'(2);
  assign take       = (state == S_IDLE) && !q_empty;
  assign q_pop      = take;
  assign clear_busy = (state == S_CLEAR);
  assign out_free   = !m_tvalid || m_tready;

  // A result is loaded into the output register in this cycle.
  assign emit = out_free && (((state == S_LOAD) && (w_op != cset_pkg::OP_POP)) ||
                             (state == S_ACC));

  // Frame start times, indexed by stack level.
  cset_ram #(.WIDTH(cset_pkg::TS_W), .DEPTH(STACK_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_waddr),
    .wdata (q_head.ts),
    .re    (start_re),
    .raddr (start_raddr),
    .rdata (start_rdata)
  );

  // Child times of the frames below the top; the top's lives in topchild.
  cset_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (topchild),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  // Per-function exclusive totals.
  cset_ram #(.WIDTH(TW), .DEPTH(FUNC_COUNT)) u_total_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .re    (tot_re),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  // A push stores its start and spills the old top's child time;
  // a pop reads its start and the parent's child time.
  always_comb begin
    start_we    = take && (q_head.op == cset_pkg::OP_PUSH);
    start_waddr = blevel[SAW-1:0];
    child_we    = start_we && (blevel != '0);
    child_waddr = lvl_m1[SAW-1:0];
    start_re    = take && (q_head.op == cset_pkg::OP_POP);
    start_raddr = lvl_m1[SAW-1:0];
    child_re    = start_re;
    child_raddr = lvl_m2[SAW-1:0];
    tot_re      = take;
    tot_raddr   = FAW'(q_head.id);
  end

  // Total write port: clearing pass after reset, then the accumulate step.
  always_comb begin
    if (state == S_CLEAR) begin
      tot_we    = 1'b1;
      tot_waddr = clr_cnt;
      tot_wdata = '0;
    end else begin
      tot_we    = (state == S_ACC) && w_inrange && out_free;
      tot_waddr = FAW'(w_id);
      tot_wdata = tot_sat;
    end
  end

  // Elapsed time of the popped call, inclusive of the end tick.
  always_comb begin
    if (w_ts >= start_rdata) begin
      elapsed_calc = {1'b0, w_ts} - {1'b0, start_rdata} + SW'(1);
    end else begin
      elapsed_calc = '0;
    end
  end

  // Exclusive slice and the parent's saturating child time.
  assign slice_calc = (elapsed > topchild) ? (elapsed - topchild) : '0;
  assign child_sum  = {1'b0, parent_child} + {1'b0, elapsed};
  assign child_sat  = child_sum[SW] ? '1 : child_sum[SW-1:0];

  // Saturating total update.
  assign tot_sum = {1'b0, total} + (TW + 1)'(slice);
  assign tot_sat = tot_sum[TW] ? '1 : tot_sum[TW-1:0];

  // Status of a start or error event.
  always_comb begin
    case (w_op)
      cset_pkg::OP_PUSH:      w_status = cset_pkg::STATUS_START;
      cset_pkg::OP_POP:       w_status = cset_pkg::STATUS_END;
      cset_pkg::OP_OVERFLOW:  w_status = cset_pkg::STATUS_OVERFLOW;
      cset_pkg::OP_UNDERFLOW: w_status = cset_pkg::STATUS_EMPTY;
      default:                w_status = cset_pkg::STATUS_EMPTY;
    endcase
  end

  // Sequencer: clear, take an event, read, compute, accumulate, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      blevel   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Valid rises with a new result and falls once the beat is taken.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + FAW'(1);
          if (clr_cnt == FAW'(FUNC_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            w_op         <= q_head.op;
            w_id         <= q_head.id;
            w_ts         <= q_head.ts;
            w_inrange    <= (32'(q_head.id) < FUNC_COUNT);
            w_has_parent <= (blevel >= LW'(2));
            if (q_head.op == cset_pkg::OP_PUSH) begin
              topchild <= '0;
              blevel   <= blevel + LW'(1);
            end else if (q_head.op == cset_pkg::OP_POP) begin
              blevel <= lvl_m1;
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          elapsed      <= elapsed_calc;
          parent_child <= child_rdata;
          total        <= w_inrange ? tot_rdata : '0;
          if (w_op == cset_pkg::OP_POP) begin
            state <= S_SLICE;
          end else if (out_free) begin
            m_tdata  <= {PAD'(0), (w_inrange ? tot_rdata : TW'(0)), SW'(0), w_id, w_status};
            state    <= S_IDLE;
          end
        end
        S_SLICE: begin
          slice <= slice_calc;
          if (w_has_parent) begin
            topchild <= child_sat;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (out_free) begin
            m_tdata  <= {PAD'(0), (w_inrange ? tot_sat : TW'(0)), slice, w_id,
                         cset_pkg::STATUS_END};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stack never holds more frames than it has room for.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    blevel <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // No result leaves while the totals are still being cleared.
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !m_tvalid)
    else $error("result during clearing pass");

  // A taken push grows the stack by one frame.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (take && q_head.op == cset_pkg::OP_PUSH) |=> blevel == $past(blevel) + LW'(1))
    else $error("push did not grow the stack");

  // A taken pop shrinks the stack by one frame.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (take && q_head.op == cset_pkg::OP_POP) |=> blevel == $past(blevel) - LW'(1))
    else $error("pop did not shrink the stack");

endmodule
